[src/rme_pkg.sv]
// Shared types and constants for the running median extract unit.
`timescale 1ns / 1ps

package rme_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]          count_t;
    typedef logic [IDX_W-1:0]          index_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT  = 2'd0,
        FUNC_EXTRACT = 2'd1,
        FUNC_CLEAR   = 2'd2
    } func_t;

    // Broadcast from the top level to every cell of the array.
    typedef struct packed {
        logic   ins_en;
        logic   ext_en;
        value_t ins_value;
    } cell_ctrl_t;

endpackage

[src/rme_cell.sv]
// One storage cell of the sorted array, with its local insert and shift logic.
`timescale 1ns / 1ps

module rme_cell (
    input  logic                clk,
    input  rme_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                shift_sel,
    input  logic                left_move,
    input  rme_pkg::value_t     left_value,
    input  rme_pkg::value_t     right_value,
    output logic                move,
    output rme_pkg::value_t     value
);

    rme_pkg::value_t value_reg;
    rme_pkg::value_t value_next;

    // A cell moves on insert when it is empty or holds a larger value.
    assign move  = !occupied || (value_reg > ctrl.ins_value);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.ins_en && move) begin
            value_next = left_move ? left_value : ctrl.ins_value;
        end else if (ctrl.ext_en && shift_sel) begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk) begin
        value_reg <= value_next;
    end

endmodule

[src/running_median_extract_unit.sv]
// Top level of the running median extract unit: cell array, count and result register.
`timescale 1ns / 1ps

// The unit holds up to CAPACITY signed 32-bit values in a row of cells kept
// in ascending order. An insert transfer places its value in order by moving
// every larger entry one cell up, all cells in the same cycle; an extract
// transfer returns the element at sorted position ceil(n/2) (the lower
// median for an even count) and closes the gap by moving the cells above it
// one cell down. A clear transfer empties the store. An extract on an empty
// store and an insert on a full store are dropped with no result, as is the
// unused function code. The unit takes one transfer per clock; the only stall
// comes from the result register, which holds one median and frees as soon as
// it is taken, so a new request is accepted in the same cycle the pending
// result leaves. No clearing pass follows reset: values in cells above the
// count never reach a result.

module running_median_extract_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic signed [31:0]    s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_median
);

    localparam int N = rme_pkg::CAPACITY;

    rme_pkg::count_t     count_reg;
    rme_pkg::count_t     count_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    rme_pkg::value_t     median_reg;
    rme_pkg::value_t     median_next;

    rme_pkg::func_t      func;
    rme_pkg::cell_ctrl_t ctrl;
    rme_pkg::index_t     mid_idx;
    rme_pkg::count_t     count_m1;
    rme_pkg::value_t     mid_value;
    logic                accept;
    logic                full;
    logic                empty;

    logic                occupied  [N];
    logic                shift_sel [N];
    logic                move      [N];
    rme_pkg::value_t     cell_val  [N];

    // The result register is the only thing that can hold a request back.
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign func     = rme_pkg::func_t'(s_func);
    assign full     = (count_reg == rme_pkg::count_t'(N));
    assign empty    = (count_reg == '0);

    // The median sits at zero-based position (n - 1) / 2.
    assign count_m1 = count_reg - rme_pkg::count_t'(1);
    assign mid_idx  = rme_pkg::index_t'(count_m1 >> 1);

    always_comb begin
        ctrl.ins_en    = 1'b0;
        ctrl.ext_en    = 1'b0;
        ctrl.ins_value = s_value;
        count_next     = count_reg;
        if (accept) begin
            case (func)
                rme_pkg::FUNC_INSERT: begin
                    if (!full) begin
                        ctrl.ins_en = 1'b1;
                        count_next  = count_reg + rme_pkg::count_t'(1);
                    end
                end
                rme_pkg::FUNC_EXTRACT: begin
                    if (!empty) begin
                        ctrl.ext_en = 1'b1;
                        count_next  = count_m1;
                    end
                end
                rme_pkg::FUNC_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Per-cell position flags and the median selection, one term per cell.
    always_comb begin
        mid_value = '0;
        for (int i = 0; i < N; i++) begin
            occupied[i]  = rme_pkg::count_t'(i) < count_reg;
            shift_sel[i] = rme_pkg::index_t'(i) >= mid_idx;
            if (rme_pkg::index_t'(i) == mid_idx) begin
                mid_value = mid_value | cell_val[i];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic            l_move;
            rme_pkg::value_t l_val;
            rme_pkg::value_t r_val;

            if (g == 0) begin : g_first
                assign l_move = 1'b0;
                assign l_val  = cell_val[g];
            end else begin : g_inner_l
                assign l_move = move[g-1];
                assign l_val  = cell_val[g-1];
            end

            if (g == N - 1) begin : g_last
                assign r_val = cell_val[g];
            end else begin : g_inner_r
                assign r_val = cell_val[g+1];
            end

            rme_cell u_cell (
                .clk         (aclk),
                .ctrl        (ctrl),
                .occupied    (occupied[g]),
                .shift_sel   (shift_sel[g]),
                .left_move   (l_move),
                .left_value  (l_val),
                .right_value (r_val),
                .move        (move[g]),
                .value       (cell_val[g])
            );
        end
    endgenerate

    // Result register: loads on a successful extract, drains on a transfer.
    always_comb begin
        m_valid_next = m_valid_reg;
        median_next  = median_reg;
        if (ctrl.ext_en) begin
            m_valid_next = 1'b1;
            median_next  = mid_value;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        median_reg <= median_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_median = median_reg;

endmodule

[sim/tb.sv]
// Self-checking testbench for the running median extract unit.
`timescale 1ns / 1ps

module tb;

    localparam logic [rme_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int     MAX_GAP      = 13;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     TOTAL_ITEMS  = 1750;
    localparam int     DRAIN_LIMIT  = 2000;
    localparam rme_pkg::value_t VALUE_MIN = 32'sh8000_0000;
    localparam rme_pkg::value_t VALUE_MAX = 32'sh7FFF_FFFF;

    typedef enum int {MEDIAN_OK, MEDIAN_UNEXPECTED, MEDIAN_WRONG} median_verdict_t;

    // Mirrors the sorted store and queues the medians that extracts must return.
    class median_scoreboard;
        rme_pkg::value_t held[$];
        rme_pkg::value_t due[$];
        int n_inserted, n_dropped_full, n_medians, n_empty_extract, n_cleared, n_unused;

        // Returns 1 when the request changed the store or produced a median.
        function bit note_request(logic [rme_pkg::FUNC_W-1:0] func, rme_pkg::value_t value);
            int pos;
            int mid;
            case (func)
                rme_pkg::FUNC_INSERT: begin
                    if (held.size() >= rme_pkg::CAPACITY) begin
                        n_dropped_full++;
                        return 1'b0;
                    end
                    // Equal values go after the ones already held.
                    pos = 0;
                    while (pos < held.size() && held[pos] <= value) pos++;
                    held.insert(pos, value);
                    n_inserted++;
                    return 1'b1;
                end
                rme_pkg::FUNC_EXTRACT: begin
                    if (held.size() == 0) begin
                        n_empty_extract++;
                        return 1'b0;
                    end
                    mid = (held.size() - 1) / 2;
                    due.push_back(held[mid]);
                    held.delete(mid);
                    n_medians++;
                    return 1'b1;
                end
                rme_pkg::FUNC_CLEAR: begin
                    held.delete();
                    n_cleared++;
                    return 1'b1;
                end
                default: begin
                    n_unused++;
                    return 1'b0;
                end
            endcase
        endfunction

        function median_verdict_t check_median(rme_pkg::value_t got,
                                               output rme_pkg::value_t want);
            want = '0;
            if (due.size() == 0) return MEDIAN_UNEXPECTED;
            want = due.pop_front();
            return (got !== want) ? MEDIAN_WRONG : MEDIAN_OK;
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [rme_pkg::FUNC_W-1:0]    s_func = rme_pkg::FUNC_INSERT;
    rme_pkg::value_t               s_value = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    rme_pkg::value_t               m_median;

    median_scoreboard sb = new();
    int  mismatch_count = 0;
    int  hold_count = 0;
    int  sent_count = 0;
    bit  tx_busy = 1'b0;
    bit  rx_busy = 1'b0;
    bit  rx_hold_req = 1'b0;

    running_median_extract_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_median (m_median)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Extremes, small values that collide often, and full-width random patterns.
    function automatic rme_pkg::value_t draw_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return rme_pkg::value_t'(int'($urandom_range(0, 8)) - 4);
            default: return rme_pkg::value_t'($urandom);
        endcase
    endfunction

    // Mode 0 leans toward filling the store, mode 1 toward draining it.
    function automatic logic [rme_pkg::FUNC_W-1:0] draw_func(int mode);
        int r;
        int ins_lim;
        r = $urandom_range(0, 199);
        ins_lim = (mode == 0) ? 160 : (mode == 1) ? 50 : 100;
        if (r < ins_lim) return rme_pkg::FUNC_INSERT;
        if (r < 196) return rme_pkg::FUNC_EXTRACT;
        if (r < 198) return rme_pkg::FUNC_CLEAR;
        return FUNC_UNUSED;
    endfunction

    // Offers one request, waits for its transfer, then idles for the gap before the next.
    task automatic send_request(input logic [rme_pkg::FUNC_W-1:0] func,
                                input rme_pkg::value_t value);
        int gap;
        s_valid <= 1'b1;
        s_func  <= func;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        void'(sb.note_request(func, value));
        sent_count++;
        gap = tx_busy ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained(int limit);
        int waited;
        waited = 0;
        while (sb.outstanding() != 0 && waited < limit) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    // Result side: random stalls, busy stretches, and a long hold-off on request.
    initial begin
        rme_pkg::value_t want;
        median_verdict_t verdict;
        int              stall;
        int              taken;
        taken = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_count++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (taken % 40 == 0) rx_busy = ($urandom_range(0, 2) == 0);
            stall = rx_busy ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            verdict = sb.check_median(m_median, want);
            if (verdict == MEDIAN_UNEXPECTED)
                report_mismatch($sformatf("median %0d arrived with none expected", m_median));
            else if (verdict == MEDIAN_WRONG)
                report_mismatch($sformatf("median %0d, expected %0d", m_median, want));
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout: outputs stopped advancing");
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int mode;
        int phase_len;
        bit pressured;
        pressured = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty store, unused code, extremes, duplicates and clears.
        send_request(rme_pkg::FUNC_EXTRACT, VALUE_MAX);
        send_request(rme_pkg::FUNC_CLEAR, VALUE_MIN);
        send_request(FUNC_UNUSED, -32'sd1);
        send_request(rme_pkg::FUNC_INSERT, VALUE_MAX);
        send_request(rme_pkg::FUNC_INSERT, VALUE_MIN);
        send_request(rme_pkg::FUNC_INSERT, '0);
        send_request(rme_pkg::FUNC_INSERT, -32'sd1);
        send_request(rme_pkg::FUNC_INSERT, '0);
        send_request(FUNC_UNUSED, '0);
        repeat (6) send_request(rme_pkg::FUNC_EXTRACT, -32'sd1);
        repeat (3) send_request(rme_pkg::FUNC_INSERT, 32'sd5);
        send_request(rme_pkg::FUNC_CLEAR, '0);
        send_request(rme_pkg::FUNC_EXTRACT, '0);
        send_request(rme_pkg::FUNC_INSERT, 32'sd1);
        send_request(rme_pkg::FUNC_INSERT, 32'sd2);
        send_request(rme_pkg::FUNC_CLEAR, -32'sd1);
        send_request(rme_pkg::FUNC_INSERT, 32'sd7);
        send_request(rme_pkg::FUNC_EXTRACT, VALUE_MIN);

        // Fill past capacity so that inserts get dropped, then take half back out.
        repeat (rme_pkg::CAPACITY + 4) send_request(rme_pkg::FUNC_INSERT, draw_value());
        repeat (rme_pkg::CAPACITY / 2) send_request(rme_pkg::FUNC_EXTRACT, draw_value());

        while (sent_count < TOTAL_ITEMS) begin
            if (!pressured && sent_count >= 600) begin
                // Let everything drain, then make the receiver hold off while
                // requests keep coming back to back, so the input stalls.
                pressured = 1'b1;
                idle_sender();
                wait_drained(DRAIN_LIMIT);
                rx_hold_req = 1'b1;
                tx_busy = 1'b1;
                repeat (12) send_request(rme_pkg::FUNC_INSERT, draw_value());
                repeat (12) send_request(rme_pkg::FUNC_EXTRACT, draw_value());
            end
            mode = $urandom_range(0, 2);
            phase_len = $urandom_range(20, 120);
            tx_busy = ($urandom_range(0, 2) == 0);
            repeat (phase_len) begin
                if (sent_count < TOTAL_ITEMS) send_request(draw_func(mode), draw_value());
            end
        end

        idle_sender();
        wait_drained(DRAIN_LIMIT);
        repeat (20) @(posedge aclk);
        if (sb.outstanding() != 0)
            report_mismatch($sformatf("%0d medians never arrived", sb.outstanding()));

        $display("Covered %0d inserts, %0d dropped on a full store, %0d medians returned.",
                 sb.n_inserted, sb.n_dropped_full, sb.n_medians);
        $display("Also %0d empty extracts, %0d clears, %0d unused codes, %0d long hold-offs.",
                 sb.n_empty_extract, sb.n_cleared, sb.n_unused, hold_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
